[sv/rag_pkg.sv]
package rag_pkg;

    localparam int OperandWidth = 16;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int NumWidth     = ProdWidth + 1;
    localparam int DenWidth     = ProdWidth;
    localparam int CntWidth     = $clog2(NumWidth + 1);

    localparam logic [1:0] KindAdd = 2'd0;
    localparam logic [1:0] KindSub = 2'd1;
    localparam logic [1:0] KindMul = 2'd2;
    localparam logic [1:0] KindDiv = 2'd3;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_mul1,
        t_st_mul2,
        t_st_form,
        t_st_gcd,
        t_st_div_num,
        t_st_div_den,
        t_st_out
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic form;
        logic gcd_step;
        logic div_start;
        logic div_sel_den;
        logic div_step;
        logic div_store;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic gcd_done;
        logic gcd_zero;
        logic div_last;
    } t_status;

endpackage

[sv/rag_ctrl.sv]
module rag_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rag_pkg::t_status  i_status,
    output rag_pkg::t_cmd     o_cmd
);

    rag_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rag_pkg::t_st_idle;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            rag_pkg::t_st_idle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rag_pkg::t_st_mul1;
                end
            end
            rag_pkg::t_st_mul1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = rag_pkg::t_st_mul2;
            end
            rag_pkg::t_st_mul2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = rag_pkg::t_st_form;
            end
            rag_pkg::t_st_form: begin
                o_cmd.form = 1'b1;
                n_state    = i_status.err ? rag_pkg::t_st_out : rag_pkg::t_st_gcd;
            end
            rag_pkg::t_st_gcd: begin
                if (i_status.gcd_done) begin
                    if (i_status.gcd_zero) begin
                        n_state = rag_pkg::t_st_out;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = rag_pkg::t_st_div_num;
                    end
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            rag_pkg::t_st_div_num: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.div_store   = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_den = 1'b1;
                    n_state           = rag_pkg::t_st_div_den;
                end
            end
            rag_pkg::t_st_div_den: begin
                o_cmd.div_step    = 1'b1;
                o_cmd.div_sel_den = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = rag_pkg::t_st_out;
                end
            end
            rag_pkg::t_st_out: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = rag_pkg::t_st_idle;
                end
            end
            default: begin
                n_state = rag_pkg::t_st_idle;
            end
        endcase
    end

endmodule

[sv/rag_dp.sv]
module rag_dp (
    input  logic                                  i_clk,
    input  logic [7:0]                            i_tuser,
    input  logic [4*rag_pkg::OperandWidth-1:0]    i_tdata,
    input  rag_pkg::t_cmd                         i_cmd,
    output rag_pkg::t_status                      o_status,
    output logic signed [rag_pkg::NumWidth-1:0]   o_res_num,
    output logic signed [rag_pkg::DenWidth-1:0]   o_res_den,
    output logic                                  o_err
);

    localparam int W  = rag_pkg::OperandWidth;
    localparam int PW = rag_pkg::ProdWidth;
    localparam int NW = rag_pkg::NumWidth;
    localparam int CW = rag_pkg::CntWidth;

    logic [1:0]          r_kind;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic signed [NW-1:0] r_num;
    logic signed [PW-1:0] r_den;
    logic [NW-1:0]        r_ga, r_gb;
    logic [CW-1:0]        r_sh;
    logic                 r_err;
    logic [NW-1:0]        r_quo, r_rem, r_dvd;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic                 r_sel_den;

    logic signed [W-1:0]  m_a, m_b, m_c, m_d;
    logic                 div_zero;
    logic signed [NW-1:0] n_num;
    logic signed [NW-1:0] den_x;
    logic [NW-1:0]        rem_sh, rem_sub;
    logic                 fits;
    logic [NW-1:0]        quo_sh;
    logic signed [NW-1:0] quo_s;

    // Operand choice for the products of the mul1 and mul2 states.
    always_comb begin
        m_a = r_an; m_b = r_bd; m_c = r_ad; m_d = r_bd;
        if (r_kind == rag_pkg::KindMul) begin
            m_b = r_bn;
        end
        if (r_kind == rag_pkg::KindDiv) begin
            m_d = r_bn;
        end
    end

    assign div_zero = (r_kind == rag_pkg::KindDiv) &&
                      (r_ad == '0 || r_bn == '0 || r_bd == '0);

    // Raw numerator from the products r_p1 and r_p3.
    always_comb begin
        case (r_kind)
            rag_pkg::KindAdd: n_num = NW'(r_p1) + NW'(r_p3);
            rag_pkg::KindSub: n_num = NW'(r_p1) - NW'(r_p3);
            default:          n_num = NW'(r_p1);
        endcase
    end

    assign den_x = NW'(r_den);

    // Restoring divider step on magnitudes.
    assign rem_sh  = {r_rem[NW-2:0], r_dvd[NW-1]};
    assign fits    = rem_sh >= r_ga;
    assign rem_sub = fits ? rem_sh - r_ga : rem_sh;
    assign quo_sh  = {r_quo[NW-2:0], fits};
    assign quo_s   = r_neg ? -$signed(quo_sh) : $signed(quo_sh);

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_tuser[1:0];
            r_an   <= i_tdata[W-1:0];
            r_ad   <= i_tdata[2*W-1:W];
            r_bn   <= i_tdata[3*W-1:2*W];
            r_bd   <= i_tdata[4*W-1:3*W];
        end
        if (i_cmd.mul1) begin
            r_p1 <= m_a * m_b;
            r_err <= div_zero;
        end
        if (i_cmd.mul2) begin
            r_p2 <= m_c * m_d;
            r_p3 <= r_bn * r_ad;
        end
        if (i_cmd.form) begin
            if (r_err) begin
                r_num <= '0;
                r_den <= '0;
            end else begin
                r_num <= n_num;
                r_den <= r_p2;
                r_ga  <= n_num[NW-1] ? NW'(-n_num) : n_num;
                r_gb  <= r_p2[PW-1] ? NW'(-{r_p2[PW-1], r_p2}) : NW'({1'b0, r_p2});
                r_sh  <= '0;
            end
        end
        // Binary gcd: one halving or one odd-odd subtraction per cycle.
        // Factors of two common to both operands are counted in r_sh.
        if (i_cmd.gcd_step) begin
            if (!r_ga[0] && !r_gb[0]) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_sh <= r_sh + 1'b1;
            end else if (!r_ga[0]) begin
                r_ga <= r_ga >> 1;
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_start) begin
            // The first start rebuilds the gcd as the divisor in r_ga.
            if (!i_cmd.div_sel_den) begin
                r_ga <= (r_ga | r_gb) << r_sh;
            end
            r_sel_den <= i_cmd.div_sel_den;
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= '0;
            if (i_cmd.div_sel_den) begin
                r_neg <= den_x[NW-1];
                r_dvd <= den_x[NW-1] ? -den_x : den_x;
            end else begin
                r_neg <= r_num[NW-1];
                r_dvd <= r_num[NW-1] ? -r_num : r_num;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= rem_sub;
            r_quo <= quo_sh;
            r_dvd <= {r_dvd[NW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        // The quotient goes to the part that the running division works on.
        if (i_cmd.div_store) begin
            if (r_sel_den) begin
                r_den <= PW'(quo_s);
            end else begin
                r_num <= quo_s;
            end
        end
    end

    // Gcd loop ends when one operand reaches zero; the other, shifted back
    // by the common factors of two, is the gcd.
    assign o_status.gcd_done = (r_ga == '0) || (r_gb == '0);
    assign o_status.gcd_zero = (r_ga == '0) && (r_gb == '0);
    assign o_status.div_last = (r_cnt == CW'(NW - 1));
    assign o_status.err      = r_err;

    assign o_res_num = r_num;
    assign o_res_den = r_den;
    assign o_err     = r_err;

endmodule

[sv/rational_alu_gcd_reduce_unit.sv]
// Channel  Direction  Contents
// s_axis   in         tdata = a_num, a_den, b_num, b_den; tuser = kind
// m_axis   out        tdata = res_num, res_den; tuser = err
//
// One item at a time. After the accepting cycle, an item passes through the
// multiply and form states, one step per halving or subtraction of the binary
// gcd loop plus one to see it end, the divisions of the numerator and of the
// denominator by the gcd, then the output state. Divide by zero and 0/0 skip
// straight to the output.
// Reset is synchronous, active low, and returns the controller to idle.
// The result holds until taken; no new item is accepted meanwhile.
module rational_alu_gcd_reduce_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [7:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // res_num, res_den
    output logic        m_axis_tuser   // err
);

    rag_pkg::t_cmd    cmd;
    rag_pkg::t_status status;
    logic signed [rag_pkg::NumWidth-1:0] res_num;
    logic signed [rag_pkg::DenWidth-1:0] res_den;
    logic err;

    rag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rag_dp u_dp (
        .i_clk     (i_clk),
        .i_tuser   (s_axis_tuser),
        .i_tdata   (s_axis_tdata),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_res_num (res_num),
        .o_res_den (res_den),
        .o_err     (err)
    );

    assign m_axis_tdata = {7'd0, res_den, res_num};
    assign m_axis_tuser = err;

endmodule
